/* design/kedt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kedt_pkg: shared types and codes for the keyed event debounce table
// Holds item modes, event kinds, register indexes and the register reset values.
// ----------------------------------------------------------------------------
package kedt_pkg;

    localparam int CFG_WIDTH = 20;

    localparam logic [1:0] MODE_EVENT  = 2'd0;
    localparam logic [1:0] MODE_TICK   = 2'd1;
    localparam logic [1:0] MODE_FLUSH  = 2'd2;
    localparam logic [1:0] MODE_IGNORE = 2'd3;

    localparam logic [1:0] KIND_CHANGE      = 2'd0;
    localparam logic [1:0] KIND_DELETE      = 2'd1;
    localparam logic [1:0] KIND_RENAME_FROM = 2'd2;
    localparam logic [1:0] KIND_RENAME_TO   = 2'd3;

    localparam logic CFG_IDX_QUIET = 1'b0;
    localparam logic CFG_IDX_MAXW  = 1'b1;

    localparam logic [CFG_WIDTH-1:0] QUIET_RESET = 20'd100;
    localparam logic [CFG_WIDTH-1:0] MAXW_RESET  = 20'd1000;

endpackage

/* design/kedt_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kedt_ram: generic simple dual-port RAM (separate write and read addresses)
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module kedt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                             aclk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH)-1:0]         raddr,
    output logic [WIDTH-1:0]                 rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    // write port and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end
endmodule

/* design/kedt_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kedt_front: input stage
// Accepts input beats, masks the fields and queues them for the engine.
// ----------------------------------------------------------------------------
module kedt_front #(
    parameter int KEY_WIDTH = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_mode,
    input  logic [31:0]           s_key,
    input  logic [1:0]            s_event_kind,
    output logic                  q_valid,
    input  logic                  q_pop,
    output logic [1:0]            q_mode,
    output logic [KEY_WIDTH-1:0]  q_key,
    output logic [1:0]            q_kind
);
    localparam int QW = 2 + KEY_WIDTH + 2;
    logic [QW-1:0] slot_reg [2];
    logic [1:0]    cnt_reg;
    logic          wp_reg, rp_reg;
    logic [KEY_WIDTH-1:0] kmask;
    logic          push;

    // masked key
    always_comb begin
        kmask = KEY_WIDTH'(s_key);
    end

    assign s_ready = (cnt_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign {q_mode, q_key, q_kind} = slot_reg[rp_reg];

    // two-entry queue toward the engine
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wp_reg] <= {s_mode, kmask, s_event_kind};
        end
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (q_pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(q_pop);
        end
    end
endmodule

/* design/kedt_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kedt_engine: table engine
// Walks the table one entry a cycle, stalling on a held beat, for lookups, tick scans and flushes.
// ----------------------------------------------------------------------------
module kedt_engine #(
    parameter int TABLE_DEPTH = 16,
    parameter int KEY_WIDTH   = 32,
    parameter int TIME_WIDTH  = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [kedt_pkg::CFG_WIDTH-1:0] idle_limit,
    input  logic [kedt_pkg::CFG_WIDTH-1:0] age_limit,
    input  logic                           q_valid,
    output logic                           q_pop,
    input  logic [1:0]                     q_mode,
    input  logic [KEY_WIDTH-1:0]           q_key,
    input  logic [1:0]                     q_kind,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [31:0]                    m_out_key,
    output logic [1:0]                     m_out_kind,
    output logic                           m_last,
    output logic [6:0]                     m_pending_count,
    output logic                           m_overflow
);
    localparam int IW = $clog2(TABLE_DEPTH + 1);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int CMPW = (TIME_WIDTH > kedt_pkg::CFG_WIDTH) ? TIME_WIDTH :
                          kedt_pkg::CFG_WIDTH;
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SCAN = 5'b00010,
        ST_DEC  = 5'b00100,
        ST_EMIT = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    state_t state_reg;
    logic [IW-1:0] idx_reg;
    logic          rd_reg;       // read data valid for idx_reg - 1
    logic [AW-1:0] ridx_reg;
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [CW-1:0] cnt_reg;
    logic [TIME_WIDTH-1:0] now_reg;
    logic [1:0] mode_reg, kind_reg;
    logic [KEY_WIDTH-1:0] key_reg;
    logic hit_reg, free_reg;
    logic [AW-1:0] hit_idx_reg, free_idx_reg;
    logic [TIME_WIDTH-1:0] hit_first_reg;

    // second walk reads the keys of the entries marked to fire
    logic pass2_reg;
    logic [TABLE_DEPTH-1:0] fmask_reg;

    // held result of the previous fire, emitted one behind to know last
    logic pend_reg;
    logic [KEY_WIDTH-1:0] pend_key_reg;
    logic [1:0] pend_kind_reg;
    logic pend_ovf_reg;

    // output register
    logic ov_reg, olast_reg, oovf_reg;
    logic [31:0] okey_reg;
    logic [1:0] okind_reg;
    logic [6:0] ocnt_reg;

    // ram ports
    logic [KEY_WIDTH-1:0]  rk;
    logic [TIME_WIDTH-1:0] rf, rl;
    logic we_k, we_f, we_l;
    logic [AW-1:0] wa;
    logic [AW-1:0] rd_addr;
    logic [KEY_WIDTH-1:0] wk;
    logic [TIME_WIDTH-1:0] wt;

    logic out_free;
    logic fire;
    logic expire;
    logic scan_stall;
    logic load_out;
    logic [TIME_WIDTH-1:0] el_last;
    logic [TIME_WIDTH-1:0] el_first;

    assign out_free = !ov_reg || m_ready;
    assign el_last  = now_reg - rl;
    assign el_first = now_reg - hit_first_reg;

    // hold the read address on the stalled entry so its data stays put
    assign rd_addr = scan_stall ? ridx_reg : idx_reg[AW-1:0];

    kedt_ram #(.WIDTH(KEY_WIDTH), .DEPTH(TABLE_DEPTH)) u_key (
        .aclk(aclk), .we(we_k), .waddr(wa), .wdata(wk), .raddr(rd_addr), .rdata(rk));
    kedt_ram #(.WIDTH(TIME_WIDTH), .DEPTH(TABLE_DEPTH)) u_first (
        .aclk(aclk), .we(we_f), .waddr(wa), .wdata(wt), .raddr(rd_addr), .rdata(rf));
    kedt_ram #(.WIDTH(TIME_WIDTH), .DEPTH(TABLE_DEPTH)) u_last (
        .aclk(aclk), .we(we_l), .waddr(wa), .wdata(wt), .raddr(rd_addr), .rdata(rl));

    // expiry test on the entry read last cycle, first walk of a tick
    always_comb begin
        expire = 1'b0;
        if (state_reg == ST_SCAN && rd_reg && !pass2_reg &&
            mode_reg == kedt_pkg::MODE_TICK && valid_reg[ridx_reg]) begin
            expire = (CMPW'(el_last) >= CMPW'(idle_limit));
        end
    end

    // fire on a marked entry during the key walk
    assign fire = (state_reg == ST_SCAN) && rd_reg && pass2_reg && fmask_reg[ridx_reg];
    assign scan_stall = fire && pend_reg && !out_free;
    assign load_out = (fire && pend_reg && out_free) ||
                      (state_reg == ST_EMIT && pend_reg && out_free);

    // table writes during the decide step
    always_comb begin
        we_k = 1'b0;
        we_f = 1'b0;
        we_l = 1'b0;
        wa   = hit_idx_reg;
        wk   = key_reg;
        wt   = now_reg;
        if (state_reg == ST_DEC && mode_reg == kedt_pkg::MODE_EVENT &&
            kind_reg == kedt_pkg::KIND_CHANGE) begin
            if (hit_reg) begin
                we_l = 1'b1;
                we_f = (CMPW'(el_first) >= CMPW'(age_limit));
            end else if (free_reg) begin
                wa   = free_idx_reg;
                we_k = 1'b1;
                we_f = 1'b1;
                we_l = 1'b1;
            end
        end
    end

    assign q_pop = (state_reg == ST_IDLE) && q_valid;

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= '0;
            cnt_reg   <= '0;
            now_reg   <= '0;
            ov_reg    <= 1'b0;
            pend_reg  <= 1'b0;
            rd_reg    <= 1'b0;
            idx_reg   <= '0;
            pass2_reg <= 1'b0;
        end else begin
            if (load_out) ov_reg <= 1'b1;
            else if (m_ready) ov_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        mode_reg  <= q_mode;
                        key_reg   <= q_key;
                        kind_reg  <= q_kind;
                        hit_reg   <= 1'b0;
                        free_reg  <= 1'b0;
                        pend_reg  <= 1'b0;
                        idx_reg   <= '0;
                        rd_reg    <= 1'b0;
                        pass2_reg <= (q_mode == kedt_pkg::MODE_FLUSH);
                        fmask_reg <= (q_mode == kedt_pkg::MODE_FLUSH) ? valid_reg : '0;
                        if (q_mode == kedt_pkg::MODE_FLUSH) begin
                            valid_reg <= '0;
                            cnt_reg   <= '0;
                        end
                        if (q_mode == kedt_pkg::MODE_TICK) now_reg <= now_reg + 1'b1;
                        if (q_mode == kedt_pkg::MODE_IGNORE) state_reg <= ST_IDLE;
                        else state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    // stall the walk while a fired beat cannot move on
                    if (!scan_stall) begin
                        if (rd_reg && mode_reg == kedt_pkg::MODE_EVENT) begin
                            if (valid_reg[ridx_reg]) begin
                                if (!hit_reg && rk == key_reg) begin
                                    hit_reg       <= 1'b1;
                                    hit_idx_reg   <= ridx_reg;
                                    hit_first_reg <= rf;
                                end
                            end else if (!free_reg) begin
                                free_reg     <= 1'b1;
                                free_idx_reg <= ridx_reg;
                            end
                        end
                        // quiet entry leaves the table and is marked to fire
                        if (expire) begin
                            fmask_reg[ridx_reg] <= 1'b1;
                            valid_reg[ridx_reg] <= 1'b0;
                            cnt_reg <= cnt_reg - 1'b1;
                        end
                        if (fire) begin
                            if (pend_reg) begin
                                okey_reg  <= 32'(pend_key_reg);
                                okind_reg <= pend_kind_reg;
                                oovf_reg  <= pend_ovf_reg;
                                olast_reg <= 1'b0;
                                ocnt_reg  <= 7'(cnt_reg);
                            end
                            pend_reg      <= 1'b1;
                            pend_key_reg  <= rk;
                            pend_kind_reg <= kedt_pkg::KIND_CHANGE;
                            pend_ovf_reg  <= 1'b0;
                        end
                        ridx_reg <= idx_reg[AW-1:0];
                        if (idx_reg <= LAST_IDX) begin
                            rd_reg  <= 1'b1;
                            idx_reg <= idx_reg + 1'b1;
                        end else begin
                            rd_reg <= 1'b0;
                            if (mode_reg == kedt_pkg::MODE_EVENT) begin
                                state_reg <= ST_DEC;
                            end else if (!pass2_reg) begin
                                pass2_reg <= 1'b1;
                                idx_reg   <= '0;
                            end else begin
                                state_reg <= ST_EMIT;
                            end
                        end
                    end
                end
                ST_DEC: begin
                    // event outcome
                    state_reg <= ST_EMIT;
                    if (kind_reg != kedt_pkg::KIND_CHANGE) begin
                        if (hit_reg) begin
                            valid_reg[hit_idx_reg] <= 1'b0;
                            cnt_reg <= cnt_reg - 1'b1;
                        end
                        pend_reg <= 1'b1;
                        pend_kind_reg <= kind_reg;
                    end else if (hit_reg) begin
                        pend_reg <= we_f;
                        pend_kind_reg <= kedt_pkg::KIND_CHANGE;
                    end else if (free_reg) begin
                        valid_reg[free_idx_reg] <= 1'b1;
                        cnt_reg <= cnt_reg + 1'b1;
                    end else begin
                        pend_reg <= 1'b1;
                        pend_kind_reg <= kedt_pkg::KIND_CHANGE;
                    end
                    pend_key_reg <= key_reg;
                    pend_ovf_reg <= !hit_reg && !free_reg &&
                                    kind_reg == kedt_pkg::KIND_CHANGE;
                end
                ST_EMIT: begin
                    // final beat of the item carries last
                    if (!pend_reg) begin
                        state_reg <= ST_IDLE;
                    end else if (out_free) begin
                        okey_reg  <= 32'(pend_key_reg);
                        okind_reg <= pend_kind_reg;
                        oovf_reg  <= pend_ovf_reg;
                        olast_reg <= 1'b1;
                        ocnt_reg  <= 7'(cnt_reg);
                        pend_reg  <= 1'b0;
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid         = ov_reg;
    assign m_out_key       = okey_reg;
    assign m_out_kind      = okind_reg;
    assign m_last          = olast_reg;
    assign m_pending_count = ocnt_reg;
    assign m_overflow      = oovf_reg;
endmodule

/* design/keyed_event_debounce_table_top.sv */
`timescale 1ns / 1ps
// sequence: an event walks the table once, a flush walks it once reading the fired keys,
//   a tick walks it twice (expiry walk, then a walk reading fired keys)
// flow: the engine takes a new item only once it is done with the last; each walk reads
//   one entry a cycle, and a result beat held by the receiver stalls the walk
// reset: aresetn synchronous active low; clears valid bits, time, queue and registers
// ----------------------------------------------------------------------------
// keyed_event_debounce_table_top: keyed event debounce table with max wait
// Input queue in front of a table engine that walks the entries one a cycle unless a result beat is held.
// ----------------------------------------------------------------------------
module keyed_event_debounce_table_top #(
    parameter int TABLE_DEPTH = 16,
    parameter int KEY_WIDTH   = 32,
    parameter int TIME_WIDTH  = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [19:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [31:0] s_key,
    input  logic [1:0]  s_event_kind,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_out_key,
    output logic [1:0]  m_out_kind,
    output logic        m_last,
    output logic [6:0]  m_pending_count,
    output logic        m_overflow
);
    logic [kedt_pkg::CFG_WIDTH-1:0] quiet_reg, maxw_reg;
    logic q_valid, q_pop;
    logic [1:0] q_mode, q_kind;
    logic [KEY_WIDTH-1:0] q_key;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quiet_reg <= kedt_pkg::QUIET_RESET;
            maxw_reg  <= kedt_pkg::MAXW_RESET;
        end else if (cfg_we) begin
            if (cfg_index == kedt_pkg::CFG_IDX_QUIET) quiet_reg <= cfg_wdata;
            if (cfg_index == kedt_pkg::CFG_IDX_MAXW)  maxw_reg  <= cfg_wdata;
        end
    end

    kedt_front #(.KEY_WIDTH(KEY_WIDTH)) u_front (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_mode(s_mode), .s_key(s_key), .s_event_kind(s_event_kind),
        .q_valid(q_valid), .q_pop(q_pop), .q_mode(q_mode), .q_key(q_key),
        .q_kind(q_kind));

    kedt_engine #(.TABLE_DEPTH(TABLE_DEPTH), .KEY_WIDTH(KEY_WIDTH),
                  .TIME_WIDTH(TIME_WIDTH)) u_engine (
        .aclk(aclk), .aresetn(aresetn), .idle_limit(quiet_reg), .age_limit(maxw_reg),
        .q_valid(q_valid), .q_pop(q_pop), .q_mode(q_mode), .q_key(q_key),
        .q_kind(q_kind), .m_valid(m_valid), .m_ready(m_ready), .m_out_key(m_out_key),
        .m_out_kind(m_out_kind), .m_last(m_last), .m_pending_count(m_pending_count),
        .m_overflow(m_overflow));
endmodule

/* design/kedt_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kedt_checker: port-level checks
// Watches the result channel of the top level.
// ----------------------------------------------------------------------------
module kedt_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_out_key,
    input logic        m_last,
    input logic [6:0]  m_pending_count,
    input logic        m_overflow
);
    // stalled beat holds its key
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_key))
        else $error("result beat changed under stall");

    // overflow only on a final beat
    a_ovf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_overflow |-> m_last)
        else $error("overflow on non-final beat");

    // count never exceeds 64
    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_pending_count <= 7'd64)
        else $error("pending count out of range");
endmodule

bind keyed_event_debounce_table_top kedt_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .m_valid(m_valid), .m_ready(m_ready),
    .m_out_key(m_out_key), .m_last(m_last), .m_pending_count(m_pending_count),
    .m_overflow(m_overflow));

/* sim/keyed_event_debounce_table_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_event_debounce_table_top_test: self-checking bench for the debounce table
// A queue-fed driver offers events, ticks and flushes; a behavioral table
// predicts every fired, passed-through and overflow beat, and a monitor
// compares each result beat field by field under random stalls.
// ----------------------------------------------------------------------------
module keyed_event_debounce_table_top_test;

    localparam int DEPTH = 16;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] key;
        logic [1:0]  kind;
    } item_t;

    typedef struct packed {
        logic [31:0] key;
        logic [1:0]  kind;
        logic        last;
        logic [6:0]  count;
        logic        ovf;
    } beat_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [19:0] cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_mode = '0;
    logic [31:0] s_key = '0;
    logic [1:0]  s_event_kind = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_out_key;
    logic [1:0]  m_out_kind;
    logic        m_last;
    logic [6:0]  m_pending_count;
    logic        m_overflow;

    keyed_event_debounce_table_top dut (.*);

    // predicted table state
    logic        tbl_valid [DEPTH];
    logic [31:0] tbl_key [DEPTH];
    logic [31:0] tbl_first [DEPTH];
    logic [31:0] tbl_last [DEPTH];
    logic [31:0] now_tick;
    logic [19:0] quiet_ticks;
    logic [19:0] wait_ticks;

    item_t pending_items[$];
    beat_t expected_beats[$];
    int    mismatches = 0;
    int    send_idle_pct = 0;
    int    recv_idle_pct = 0;
    int    recv_hold = 0;
    int    quiet_cycles = 0;
    bit    timed_out = 0;

    // clock
    initial begin
        forever #1 aclk = ~aclk;
    end

    // apply one accepted item to the table copy and queue its result beats
    task automatic predict_item(input item_t it);
        beat_t fired[$];
        beat_t b;
        int hit;
        int free_slot;
        int cnt;
        hit = -1;
        free_slot = -1;
        b = '0;
        if (it.mode == kedt_pkg::MODE_EVENT) begin
            for (int i = 0; i < DEPTH; i++) begin
                if (tbl_valid[i]) begin
                    if (hit < 0 && tbl_key[i] == it.key) hit = i;
                end else if (free_slot < 0) begin
                    free_slot = i;
                end
            end
            if (it.kind != kedt_pkg::KIND_CHANGE) begin
                if (hit >= 0) tbl_valid[hit] = 1'b0;
                b.key = it.key; b.kind = it.kind;
                fired.push_back(b);
            end else if (hit >= 0) begin
                if (now_tick - tbl_first[hit] >= 32'(wait_ticks)) begin
                    tbl_first[hit] = now_tick;
                    b.key = it.key;
                    fired.push_back(b);
                end
                tbl_last[hit] = now_tick;
            end else if (free_slot >= 0) begin
                tbl_valid[free_slot] = 1'b1;
                tbl_key[free_slot] = it.key;
                tbl_first[free_slot] = now_tick;
                tbl_last[free_slot] = now_tick;
            end else begin
                b.key = it.key; b.ovf = 1'b1;
                fired.push_back(b);
            end
        end else if (it.mode == kedt_pkg::MODE_TICK || it.mode == kedt_pkg::MODE_FLUSH) begin
            if (it.mode == kedt_pkg::MODE_TICK) now_tick = now_tick + 1;
            for (int i = 0; i < DEPTH; i++) begin
                if (tbl_valid[i] && (it.mode == kedt_pkg::MODE_FLUSH ||
                        now_tick - tbl_last[i] >= 32'(quiet_ticks))) begin
                    tbl_valid[i] = 1'b0;
                    b = '0;
                    b.key = tbl_key[i];
                    fired.push_back(b);
                end
            end
        end
        cnt = 0;
        foreach (tbl_valid[i]) cnt += tbl_valid[i];
        foreach (fired[k]) begin
            fired[k].count = 7'(cnt);
            fired[k].last = (k == fired.size() - 1);
            expected_beats.push_back(fired[k]);
        end
    endtask

    // input beat driver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) predict_item({s_mode, s_key, s_event_kind});
            if (!s_valid || s_ready) begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    item_t it;
                    it = pending_items.pop_front();
                    s_valid <= 1'b1;
                    s_mode <= it.mode;
                    s_key <= it.key;
                    s_event_kind <= it.kind;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result beat monitor and receiver stalls
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                beat_t got;
                beat_t want;
                got = {m_out_key, m_out_kind, m_last, m_pending_count, m_overflow};
                if (expected_beats.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result beat %p", got);
                end else begin
                    want = expected_beats.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p actual %p", want, got);
                    end
                end
            end
            if (recv_hold > 0) begin
                recv_hold <= recv_hold - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) timed_out <= 1'b1;
    end

    task automatic add_item(input logic [1:0] mode, input logic [31:0] key,
                            input logic [1:0] kind);
        item_t it;
        it.mode = mode; it.key = key; it.kind = kind;
        pending_items.push_back(it);
    endtask

    // wait for every result, then long enough for queued items with no result
    task automatic drain();
        while (pending_items.size() > 0 || s_valid || expected_beats.size() > 0) begin
            @(posedge aclk);
            if (timed_out) begin
                $display("keyed_event_debounce_table_top_test NOT OK");
                $finish;
            end
        end
        repeat (200) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [19:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == kedt_pkg::CFG_IDX_QUIET) quiet_ticks = val;
        else wait_ticks = val;
    endtask

    // one random phase over a small key pool with mostly change events
    task automatic random_phase(input int n);
        logic [31:0] pool [8];
        int r;
        foreach (pool[i]) pool[i] = $urandom();
        pool[0] = 32'hFFFF_FFFF;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 55) add_item(kedt_pkg::MODE_EVENT, pool[$urandom_range(7)],
                                 kedt_pkg::KIND_CHANGE);
            else if (r < 65) add_item(kedt_pkg::MODE_EVENT, $urandom(),
                                      kedt_pkg::KIND_CHANGE);
            else if (r < 75) add_item(kedt_pkg::MODE_EVENT, pool[$urandom_range(7)],
                                      2'($urandom_range(3, 1)));
            else if (r < 92) add_item(kedt_pkg::MODE_TICK, $urandom(), 2'($urandom()));
            else if (r < 97) add_item(kedt_pkg::MODE_FLUSH, $urandom(), 2'($urandom()));
            else add_item(kedt_pkg::MODE_IGNORE, $urandom(), 2'($urandom()));
        end
    endtask

    initial begin
        foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
        now_tick = '0;
        quiet_ticks = kedt_pkg::QUIET_RESET;
        wait_ticks = kedt_pkg::MAXW_RESET;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: small windows, fill past capacity, delete and rename paths
        write_reg(kedt_pkg::CFG_IDX_QUIET, 20'd2);
        write_reg(kedt_pkg::CFG_IDX_MAXW, 20'd0);
        add_item(kedt_pkg::MODE_EVENT, 32'h0, kedt_pkg::KIND_CHANGE);
        add_item(kedt_pkg::MODE_EVENT, 32'h0, kedt_pkg::KIND_CHANGE);
        for (int i = 1; i <= 16; i++)
            add_item(kedt_pkg::MODE_EVENT, 32'hFFFF_FFF0 + i, kedt_pkg::KIND_CHANGE);
        add_item(kedt_pkg::MODE_EVENT, 32'h1234_5678, kedt_pkg::KIND_DELETE);
        add_item(kedt_pkg::MODE_EVENT, 32'hFFFF_FFF1, kedt_pkg::KIND_RENAME_FROM);
        add_item(kedt_pkg::MODE_EVENT, 32'hFFFF_FFF2, kedt_pkg::KIND_RENAME_TO);
        add_item(kedt_pkg::MODE_EVENT, 32'hFFFF_FFF3, kedt_pkg::KIND_DELETE);
        add_item(kedt_pkg::MODE_IGNORE, 32'hAAAA_5555, kedt_pkg::KIND_RENAME_TO);
        add_item(kedt_pkg::MODE_TICK, 32'h5555_AAAA, kedt_pkg::KIND_CHANGE);
        add_item(kedt_pkg::MODE_TICK, 32'h0, kedt_pkg::KIND_CHANGE);
        add_item(kedt_pkg::MODE_FLUSH, 32'h0, kedt_pkg::KIND_CHANGE);
        add_item(kedt_pkg::MODE_FLUSH, 32'h0, kedt_pkg::KIND_CHANGE);
        // long receiver hold while the sender keeps offering
        recv_hold = 400;
        drain();

        send_idle_pct = 12; recv_idle_pct = 54;
        write_reg(kedt_pkg::CFG_IDX_QUIET, 20'd3);
        write_reg(kedt_pkg::CFG_IDX_MAXW, 20'd5);
        random_phase(55);
        drain();

        send_idle_pct = 54; recv_idle_pct = 12;
        write_reg(kedt_pkg::CFG_IDX_QUIET, 20'hFFFFF);
        write_reg(kedt_pkg::CFG_IDX_MAXW, 20'hFFFFF);
        random_phase(30);
        drain();

        send_idle_pct = 0; recv_idle_pct = 0;
        write_reg(kedt_pkg::CFG_IDX_QUIET, 20'd0);
        write_reg(kedt_pkg::CFG_IDX_MAXW, 20'd2);
        random_phase(60);
        drain();

        if (mismatches == 0)
            $display("keyed_event_debounce_table_top_test OK");
        else
            $display("keyed_event_debounce_table_top_test NOT OK");
        $finish;
    end
endmodule

/* keyed_event_debounce_table_top.f */
design/kedt_pkg.sv
design/kedt_ram.sv
design/kedt_front.sv
design/kedt_engine.sv
design/keyed_event_debounce_table_top.sv
design/kedt_checker.sv
sim/keyed_event_debounce_table_top_test.sv
